FILE: rtl/core/assert_macros.svh
// Assertion macros for the core RTL.
// Depends on a clock named i_clk and an active-low reset named i_rst_n at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SSDF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SSDF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/ssdf_pkg.sv
// Types, codes, constants and the glyph table of the seven-segment formatter.
// No dependencies.
package ssdf_pkg;

    localparam int unsigned DigitCount = 4;

    typedef logic [6:0] t_seg;

    typedef enum logic [1:0] {
        ACT_DECIMAL   = 2'd0,
        ACT_HEX       = 2'd1,
        ACT_TIME      = 2'd2,
        ACT_SET_DIGIT = 2'd3
    } t_action;

    localparam t_seg        SEG_BLANK     = 7'h00;
    localparam t_seg        SEG_E_LET     = 7'h79;
    localparam t_seg        SEG_R_LET     = 7'h50;
    localparam logic [15:0] DEC_MAX       = 16'd9999;
    localparam logic [7:0]  PAIR_MAX      = 8'd99;
    localparam logic [15:0] CODE_BLANK    = 16'h0010;
    localparam logic [3:0]  ERR_BAD_INDEX = 4'h1;
    localparam logic [2:0]  IDX_FIRST     = 3'd1;
    localparam logic [2:0]  IDX_LAST      = 3'd4;

    // Reciprocals for constant division of values below 10000 (and below 100).
    localparam logic [15:0] RECIP_TEN      = 16'd52429;  // >> 19
    localparam logic [12:0] RECIP_HUNDRED  = 13'd5243;   // >> 19
    localparam logic [13:0] RECIP_THOUSAND = 14'd8389;   // >> 23
    localparam logic [6:0]  RECIP_TEN_PAIR = 7'd103;     // >> 10

    function automatic t_seg glyph(input logic [3:0] code);
        t_seg seg;
        case (code)
            4'h0:    seg = 7'h3F;
            4'h1:    seg = 7'h06;
            4'h2:    seg = 7'h5B;
            4'h3:    seg = 7'h4F;
            4'h4:    seg = 7'h66;
            4'h5:    seg = 7'h6D;
            4'h6:    seg = 7'h7D;
            4'h7:    seg = 7'h07;
            4'h8:    seg = 7'h7F;
            4'h9:    seg = 7'h67;
            4'hA:    seg = 7'h77;
            4'hB:    seg = 7'h7C;
            4'hC:    seg = 7'h39;
            4'hD:    seg = 7'h5E;
            4'hE:    seg = 7'h79;
            4'hF:    seg = 7'h71;
            default: seg = SEG_BLANK;
        endcase
        return seg;
    endfunction

endpackage

FILE: rtl/core/ssdf_if.sv
// Valid/ready channels of the seven-segment formatter: command in, display out.
// Depends on ssdf_pkg for the segment type.
interface ssdf_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [15:0] value;
    logic [7:0]  second_value;
    logic [2:0]  digit_index;

    modport source (output valid, output action, output value, output second_value,
                    output digit_index, input ready);
    modport sink   (input valid, input action, input value, input second_value,
                    input digit_index, output ready);
endinterface

interface ssdf_disp_if;
    logic           valid;
    logic           ready;
    ssdf_pkg::t_seg digit_one_segments;
    ssdf_pkg::t_seg digit_two_segments;
    ssdf_pkg::t_seg digit_three_segments;
    ssdf_pkg::t_seg digit_four_segments;
    logic           colon_lit;

    modport source (output valid, output digit_one_segments, output digit_two_segments,
                    output digit_three_segments, output digit_four_segments,
                    output colon_lit, input ready);
    modport sink   (input valid, input digit_one_segments, input digit_two_segments,
                    input digit_three_segments, input digit_four_segments,
                    input colon_lit, output ready);
endinterface

FILE: rtl/core/seven_segment_display_formatter_core.sv
// Four-digit seven-segment formatter core: command register, formatting logic, display register.
// Depends on ssdf_pkg, ssdf_if.sv and assert_macros.svh.
//
// Usage:
//   i_cmd carries one command per transfer: show a decimal number, a hex number, a time
//   (two pairs, colon on) or set one digit to a glyph. o_disp carries the whole display
//   (four segment patterns and the colon) once for every command, in command order.
//   Path: a command taken on i_cmd is held in the command register, then loaded into the
//   display register, which drives o_disp.
//   Throughput: one command per cycle while o_disp takes each display. The command register
//   and the display register form a two-stage pipe, and the formatting (constant-reciprocal
//   digit split, glyph table, range checks) sits combinationally between them.
//   The display register is also the display state, so it updates only when a command
//   moves out of the command register.
//   Reset: both stages empty, all digits blank, colon off.
//   Stall: while o_disp is held, the display stays put; one more command waits in the
//   command register, and i_cmd.ready drops until the display transfers.
module seven_segment_display_formatter_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ssdf_cmd_if.sink    i_cmd,
    ssdf_disp_if.source o_disp
);
    import ssdf_pkg::*;

    logic        r_s1_valid;
    t_action     r_action;
    logic [15:0] r_value;
    logic [7:0]  r_second;
    logic [2:0]  r_index;

    logic        r_out_valid;
    t_seg        r_digits [DigitCount];
    logic        r_colon;
    t_seg        n_digits [DigitCount];
    logic        n_colon;

    logic        s1_go;
    logic        in_take;

    logic [13:0] dec_val;
    logic [29:0] prod_ten;
    logic [26:0] prod_hun;
    logic [27:0] prod_thou;
    logic [9:0]  q_ten;
    logic [6:0]  q_hun;
    logic [3:0]  q_thou;
    logic [13:0] rem_ones;
    logic [9:0]  rem_tens;
    logic [6:0]  rem_hun;
    logic        dec_bad;

    logic [6:0]  pair_a;
    logic [6:0]  pair_b;
    logic [13:0] prod_a;
    logic [13:0] prod_b;
    logic [3:0]  tens_a;
    logic [3:0]  tens_b;
    logic [6:0]  ones_a;
    logic [6:0]  ones_b;
    logic        pair_bad;

    logic        code_glyph;
    logic        code_blank;
    logic        idx_bad;
    logic [2:0]  idx_off;
    logic [1:0]  pos;

    assign s1_go       = r_s1_valid && (!r_out_valid || o_disp.ready);
    assign i_cmd.ready = !r_s1_valid || s1_go;
    assign in_take     = i_cmd.valid && i_cmd.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_colon     <= 1'b0;
            for (int i = 0; i < DigitCount; i++) begin
                r_digits[i] <= SEG_BLANK;
            end
        end else begin
            if (i_cmd.ready) begin
                r_s1_valid <= i_cmd.valid;
            end
            if (s1_go) begin
                r_out_valid <= 1'b1;
                r_digits    <= n_digits;
                r_colon     <= n_colon;
            end else if (o_disp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_action <= t_action'(i_cmd.action);
            r_value  <= i_cmd.value;
            r_second <= i_cmd.second_value;
            r_index  <= i_cmd.digit_index;
        end
    end

    // Decimal split: three parallel reciprocal multiplies, then subtract ten times the next quotient.
    assign dec_val   = r_value[13:0];
    assign prod_ten  = 30'(dec_val) * 30'(RECIP_TEN);
    assign prod_hun  = 27'(dec_val) * 27'(RECIP_HUNDRED);
    assign prod_thou = 28'(dec_val) * 28'(RECIP_THOUSAND);
    assign q_ten     = prod_ten[28:19];
    assign q_hun     = prod_hun[25:19];
    assign q_thou    = prod_thou[26:23];
    assign rem_ones  = dec_val - ({1'b0, q_ten, 3'b000} + {3'b000, q_ten, 1'b0});
    assign rem_tens  = q_ten - ({q_hun, 3'b000} + {2'b00, q_hun, 1'b0});
    assign rem_hun   = q_hun - ({q_thou, 3'b000} + {2'b00, q_thou, 1'b0});
    assign dec_bad   = r_value > DEC_MAX;

    assign pair_a   = r_value[6:0];
    assign pair_b   = r_second[6:0];
    assign prod_a   = 14'(pair_a) * 14'(RECIP_TEN_PAIR);
    assign prod_b   = 14'(pair_b) * 14'(RECIP_TEN_PAIR);
    assign tens_a   = prod_a[13:10];
    assign tens_b   = prod_b[13:10];
    assign ones_a   = pair_a - ({tens_a, 3'b000} + {2'b00, tens_a, 1'b0});
    assign ones_b   = pair_b - ({tens_b, 3'b000} + {2'b00, tens_b, 1'b0});
    assign pair_bad = (r_value > {8'h00, PAIR_MAX}) || (r_second > PAIR_MAX);

    assign code_glyph = r_value[15:4] == 12'h000;
    assign code_blank = r_value == CODE_BLANK;
    assign idx_bad    = (r_index < IDX_FIRST) || (r_index > IDX_LAST);
    assign idx_off    = r_index - IDX_FIRST;
    assign pos        = idx_off[1:0];

    always_comb begin
        n_digits = r_digits;
        n_colon  = r_colon;
        case (r_action)
            ACT_DECIMAL: begin
                if (dec_bad) begin
                    n_digits[0] = SEG_E_LET;
                    n_digits[1] = SEG_R_LET;
                    n_digits[2] = SEG_R_LET;
                    n_digits[3] = SEG_BLANK;
                end else begin
                    n_digits[0] = glyph(q_thou);
                    n_digits[1] = glyph(rem_hun[3:0]);
                    n_digits[2] = glyph(rem_tens[3:0]);
                    n_digits[3] = glyph(rem_ones[3:0]);
                end
            end
            ACT_HEX: begin
                n_digits[0] = glyph(r_value[15:12]);
                n_digits[1] = glyph(r_value[11:8]);
                n_digits[2] = glyph(r_value[7:4]);
                n_digits[3] = glyph(r_value[3:0]);
            end
            ACT_TIME: begin
                if (pair_bad) begin
                    n_digits[0] = SEG_E_LET;
                    n_digits[1] = SEG_R_LET;
                    n_digits[2] = SEG_R_LET;
                    n_digits[3] = SEG_BLANK;
                end else begin
                    n_digits[0] = glyph(tens_a);
                    n_digits[1] = glyph(ones_a[3:0]);
                    n_digits[2] = glyph(tens_b);
                    n_digits[3] = glyph(ones_b[3:0]);
                    n_colon     = 1'b1;
                end
            end
            ACT_SET_DIGIT: begin
                if (idx_bad) begin
                    n_digits[0] = SEG_E_LET;
                    n_digits[1] = SEG_R_LET;
                    n_digits[2] = SEG_R_LET;
                    n_digits[3] = glyph(ERR_BAD_INDEX);
                end else if (code_glyph) begin
                    n_digits[pos] = glyph(r_value[3:0]);
                end else if (code_blank) begin
                    n_digits[pos] = SEG_BLANK;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_disp.valid                = r_out_valid;
    assign o_disp.digit_one_segments   = r_digits[0];
    assign o_disp.digit_two_segments   = r_digits[1];
    assign o_disp.digit_three_segments = r_digits[2];
    assign o_disp.digit_four_segments  = r_digits[3];
    assign o_disp.colon_lit            = r_colon;

`include "assert_macros.svh"

    `SSDF_ASSERT_NXT(a_colon_sticky, r_colon, r_colon, "colon turned off outside reset")
    `SSDF_ASSERT_IMP(a_no_overwrite, r_out_valid && !o_disp.ready, !s1_go, "display overwritten while held")
    `SSDF_ASSERT_NXT(a_err_one, s1_go && r_action == ACT_SET_DIGIT && idx_bad, r_digits[0] == SEG_E_LET && r_digits[3] == glyph(ERR_BAD_INDEX), "bad digit index not shown as Err1")

endmodule

FILE: verif/tb.sv
// Testbench for seven_segment_display_formatter_core: drives command transfers with random
// gaps and a long display hold-off, predicts every display in a scoreboard class and checks it.
// Depends on ssdf_pkg and the ssdf_cmd_if / ssdf_disp_if interfaces.
module tb;
    import ssdf_pkg::*;

    localparam int unsigned RESET_CYCLES = 12;
    localparam int unsigned RANDOM_ITEMS = 800;
    localparam int unsigned HOLD_CYCLES  = 80;
    localparam int unsigned STALL_LIMIT  = 1000;
    localparam int unsigned IDLE_PCT     = 11;

    typedef struct packed {
        t_seg digit_one;
        t_seg digit_two;
        t_seg digit_three;
        t_seg digit_four;
        logic colon;
    } t_display;

    class display_scoreboard;
        t_seg     digits[4];
        logic     colon_on;
        t_display expected_displays[$];
        int       faults;

        function new();
            foreach (digits[i]) digits[i] = SEG_BLANK;
            colon_on = 1'b0;
            faults   = 0;
        endfunction

        function t_seg glyph_seg(int unsigned code);
            case (code)
                0:       return 7'h3F;
                1:       return 7'h06;
                2:       return 7'h5B;
                3:       return 7'h4F;
                4:       return 7'h66;
                5:       return 7'h6D;
                6:       return 7'h7D;
                7:       return 7'h07;
                8:       return 7'h7F;
                9:       return 7'h67;
                10:      return 7'h77;
                11:      return 7'h7C;
                12:      return 7'h39;
                13:      return 7'h5E;
                14:      return 7'h79;
                default: return 7'h71;
            endcase
        endfunction

        function void put_glyph(int unsigned code, int pos);
            if (code < 16)
                digits[pos] = glyph_seg(code);
            else if (code == CODE_BLANK)
                digits[pos] = SEG_BLANK;
        endfunction

        function void show_fault(bit with_one);
            digits[0] = SEG_E_LET;
            digits[1] = SEG_R_LET;
            digits[2] = SEG_R_LET;
            digits[3] = with_one ? glyph_seg(ERR_BAD_INDEX) : SEG_BLANK;
        endfunction

        function void note_command(t_action act, logic [15:0] value, logic [7:0] second,
                                   logic [2:0] index);
            int unsigned v;
            int unsigned s;
            v = value;
            s = second;
            case (act)
                ACT_DECIMAL: begin
                    if (v > DEC_MAX) begin
                        show_fault(1'b0);
                    end else begin
                        put_glyph(v / 1000, 0);
                        put_glyph((v / 100) % 10, 1);
                        put_glyph((v / 10) % 10, 2);
                        put_glyph(v % 10, 3);
                    end
                end
                ACT_HEX: begin
                    put_glyph(value[15:12], 0);
                    put_glyph(value[11:8], 1);
                    put_glyph(value[7:4], 2);
                    put_glyph(value[3:0], 3);
                end
                ACT_TIME: begin
                    if (v > PAIR_MAX || s > PAIR_MAX) begin
                        show_fault(1'b0);
                    end else begin
                        put_glyph(v / 10, 0);
                        put_glyph(v % 10, 1);
                        put_glyph(s / 10, 2);
                        put_glyph(s % 10, 3);
                        colon_on = 1'b1;
                    end
                end
                default: begin
                    if (index < IDX_FIRST || index > IDX_LAST)
                        show_fault(1'b1);
                    else
                        put_glyph(v, int'(index) - 1);
                end
            endcase
            expected_displays.push_back({digits[0], digits[1], digits[2], digits[3], colon_on});
        endfunction

        function void check_field(string name, t_seg want, t_seg got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
                faults++;
            end
        endfunction

        function void check_display(t_display got);
            t_display want;
            if (expected_displays.size() == 0) begin
                $display("%0t: unexpected display transfer, expected none actual %h",
                         $time, got);
                faults++;
                return;
            end
            want = expected_displays.pop_front();
            check_field("digit_one_segments", want.digit_one, got.digit_one);
            check_field("digit_two_segments", want.digit_two, got.digit_two);
            check_field("digit_three_segments", want.digit_three, got.digit_three);
            check_field("digit_four_segments", want.digit_four, got.digit_four);
            check_field("colon_lit", {6'b0, want.colon}, {6'b0, got.colon});
        endfunction

        function int pending();
            return expected_displays.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    ssdf_cmd_if  cmd ();
    ssdf_disp_if disp ();

    display_scoreboard board;
    bit          steady_flow  = 1'b0;
    bit          hold_display = 1'b0;
    int unsigned stall_cycles = 0;

    seven_segment_display_formatter_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_disp  (disp)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    task automatic send_cmd(t_action act, logic [15:0] value, logic [7:0] second,
                            logic [2:0] index);
        if (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
            cmd.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd.valid        <= 1'b1;
        cmd.action       <= act;
        cmd.value        <= value;
        cmd.second_value <= second;
        cmd.digit_index  <= index;
        @(posedge i_clk);
        while (!cmd.ready) @(posedge i_clk);
    endtask

    task automatic send_random();
        t_action     act;
        logic [15:0] value;
        logic [7:0]  second;
        logic [2:0]  index;
        act    = t_action'($urandom_range(3));
        value  = 16'($urandom_range(16'hFFFF));
        second = 8'($urandom_range(8'hFF));
        index  = 3'($urandom_range(7));
        case (act)
            ACT_DECIMAL:
                if ($urandom_range(9) != 0) value = 16'($urandom_range(DEC_MAX));
            ACT_TIME:
                if ($urandom_range(9) != 0) begin
                    value  = 16'($urandom_range(PAIR_MAX));
                    second = 8'($urandom_range(PAIR_MAX));
                end
            ACT_SET_DIGIT: begin
                if ($urandom_range(4) != 0) index = 3'($urandom_range(IDX_LAST, IDX_FIRST));
                if ($urandom_range(5) != 0) value = 16'($urandom_range(CODE_BLANK));
            end
            default: ;
        endcase
        send_cmd(act, value, second, index);
    endtask

    initial begin
        disp.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                disp.ready <= 1'b0;
            end else if (hold_display) begin
                disp.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
                hold_display = 1'b0;
            end else if (steady_flow) begin
                disp.ready <= 1'b1;
            end else begin
                disp.ready <= ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (disp.valid && disp.ready)
                board.check_display({disp.digit_one_segments, disp.digit_two_segments,
                                     disp.digit_three_segments, disp.digit_four_segments,
                                     disp.colon_lit});
            if (cmd.valid && cmd.ready)
                board.note_command(t_action'(cmd.action), cmd.value, cmd.second_value,
                                   cmd.digit_index);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (cmd.valid && cmd.ready) || (disp.valid && disp.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        board = new();
        i_rst_n          <= 1'b0;
        cmd.valid        <= 1'b0;
        cmd.action       <= ACT_DECIMAL;
        cmd.value        <= '0;
        cmd.second_value <= '0;
        cmd.digit_index  <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_cmd(ACT_DECIMAL, 16'd0, 8'd0, 3'd0);
        send_cmd(ACT_DECIMAL, 16'd9999, 8'hFF, 3'd7);
        send_cmd(ACT_DECIMAL, 16'd10000, 8'd0, 3'd0);
        send_cmd(ACT_DECIMAL, 16'hFFFF, 8'd0, 3'd0);
        send_cmd(ACT_DECIMAL, 16'd1234, 8'd0, 3'd0);
        send_cmd(ACT_HEX, 16'h0000, 8'd0, 3'd0);
        send_cmd(ACT_HEX, 16'hFFFF, 8'd0, 3'd0);
        send_cmd(ACT_HEX, 16'h89AB, 8'd0, 3'd0);
        send_cmd(ACT_HEX, 16'hCDE7, 8'd0, 3'd0);
        send_cmd(ACT_TIME, 16'd100, 8'd5, 3'd0);
        send_cmd(ACT_TIME, 16'd5, 8'd100, 3'd0);
        send_cmd(ACT_TIME, 16'd0, 8'd0, 3'd0);
        send_cmd(ACT_TIME, 16'd99, 8'd99, 3'd0);
        send_cmd(ACT_TIME, 16'hFFFF, 8'hFF, 3'd7);
        send_cmd(ACT_TIME, 16'd12, 8'd34, 3'd0);
        send_cmd(ACT_SET_DIGIT, 16'd0, 8'd0, 3'd1);
        send_cmd(ACT_SET_DIGIT, 16'd15, 8'd0, 3'd4);
        send_cmd(ACT_SET_DIGIT, CODE_BLANK, 8'd0, 3'd2);
        send_cmd(ACT_SET_DIGIT, 16'd17, 8'd0, 3'd3);
        send_cmd(ACT_SET_DIGIT, 16'hFFFF, 8'd0, 3'd3);
        send_cmd(ACT_SET_DIGIT, 16'd5, 8'd0, 3'd0);
        send_cmd(ACT_SET_DIGIT, 16'd9, 8'd0, 3'd2);
        send_cmd(ACT_SET_DIGIT, 16'd5, 8'd0, 3'd5);
        send_cmd(ACT_SET_DIGIT, 16'd5, 8'd0, 3'd7);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 300) hold_display = 1'b1;
            steady_flow = (n >= 450 && n < 600);
            send_random();
        end
        cmd.valid <= 1'b0;

        while (board.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (board.faults == 0 && board.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

FILE: seven_segment_display_formatter_core.f
+incdir+rtl/core
rtl/core/ssdf_pkg.sv
rtl/core/ssdf_if.sv
rtl/core/seven_segment_display_formatter_core.sv
verif/tb.sv
